// ----- rtl/core/mhpq_pkg.sv -----
// Shared types and constants for the max-heap priority queue.
// Used by the channel interfaces, the sequencer, the top level and the checker.
// No dependencies.
package mhpq_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_START,
        S_INS_CMP,
        S_RM_TOP,
        S_RM_LAST,
        S_RM_LEFT,
        S_RM_RIGHT,
        S_RM_CMP,
        S_RM_PUT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    typedef struct packed {
        logic                valid;
        status_t             status;
        logic [VALUE_W-1:0]  removed_value;
        logic [COUNT_W-1:0]  entry_count;
    } resp_t;

endpackage

// ----- rtl/core/mhpq_if.sv -----
// Channel interfaces of the max-heap priority queue: request and response.
// Depends on mhpq_pkg for the payload widths.
interface mhpq_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 mode;
    logic signed [mhpq_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mhpq_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [mhpq_pkg::STATUS_W-1:0]        status;
    logic signed [mhpq_pkg::VALUE_W-1:0]  removed_value;
    logic [mhpq_pkg::COUNT_W-1:0]         entry_count;

    modport source (output valid, output status, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input entry_count,
                    output ready);
endinterface

// ----- rtl/core/max_heap_priority_queue.sv -----
// Top level of the max-heap priority queue: sequencer, heap store and the
// response register. Depends on mhpq_pkg, mhpq_if, mhpq_store and mhpq_seq.
//
//   Channel | Role   | Payload                            | Transaction
//   --------+--------+------------------------------------+----------------------
//   req     | sink   | mode, value                        | one insert or remove
//   rsp     | source | status, removed_value, entry_count | one result per request
//
// Insert: a start step, then one compare per level the value climbs. Remove: read the
// top, read the last entry, then per level visited a left read, a right read when present
// and a compare, plus a put when the entry settles at a leaf; full and empty cases go
// straight to the response. The registered-read store and the one shared comparator set
// these steps. req.ready is high only while idle; a second result holds the sequencer
// until the rsp register drains. Reset clears the count, the sequencer state and rsp.valid.
module max_heap_priority_queue #(
    parameter int CAPACITY   = mhpq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    mhpq_req_if.sink   req,
    mhpq_rsp_if.source rsp
);

    localparam int AW = $clog2(CAPACITY);

    mhpq_pkg::mem_ctl_t  mem_ctl;
    logic [AW-1:0]       mem_rd_addr;
    logic [AW-1:0]       mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic [DATA_WIDTH-1:0] mem_rd_data;
    mhpq_pkg::resp_t     resp;
    logic                resp_ready;

    logic                             out_valid_reg, out_valid_next;
    logic [mhpq_pkg::STATUS_W-1:0]    out_status_reg;
    logic [mhpq_pkg::VALUE_W-1:0]     out_removed_reg;
    logic [mhpq_pkg::COUNT_W-1:0]     out_count_reg;
    logic                             out_load;

    mhpq_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .mem_ctl     (mem_ctl),
        .mem_rd_addr (mem_rd_addr),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data),
        .resp        (resp),
        .resp_ready  (resp_ready)
    );

    mhpq_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .clk     (clk),
        .ctl     (mem_ctl),
        .rd_addr (mem_rd_addr),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    // Take a new result when the register is empty or is being drained.
    assign resp_ready = !out_valid_reg || rsp.ready;
    assign out_load   = resp.valid && resp_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg  <= resp.status;
            out_removed_reg <= resp.removed_value;
            out_count_reg   <= resp.entry_count;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.entry_count   = out_count_reg;

endmodule

// ----- rtl/core/mhpq_store.sv -----
// Heap storage: one write port and one read port with registered read data.
// Depends on mhpq_pkg for the port control struct.
module mhpq_store #(
    parameter int CAPACITY   = mhpq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  mhpq_pkg::mem_ctl_t          ctl,
    input  logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]       wr_data,
    output logic [DATA_WIDTH-1:0]       rd_data
);

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/mhpq_seq.sv -----
// Sequencer of the max-heap priority queue: sift-up and sift-down over the
// heap store, driven through one shared key comparator.
// Depends on mhpq_pkg and mhpq_req_if.
module mhpq_seq #(
    parameter int CAPACITY   = mhpq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = mhpq_pkg::DATA_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    mhpq_req_if.sink                    req,
    output mhpq_pkg::mem_ctl_t          mem_ctl,
    output logic [$clog2(CAPACITY)-1:0] mem_rd_addr,
    output logic [$clog2(CAPACITY)-1:0] mem_wr_addr,
    output logic [DATA_WIDTH-1:0]       mem_wr_data,
    input  logic [DATA_WIDTH-1:0]       mem_rd_data,
    output mhpq_pkg::resp_t             resp,
    input  logic                        resp_ready
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int PW   = $clog2(CAPACITY + 1);
    localparam int CW   = PW + 1;
    localparam int DW   = DATA_WIDTH;
    localparam int VW   = mhpq_pkg::VALUE_W;
    localparam int CNTW = mhpq_pkg::COUNT_W;
    localparam logic [DW-1:0] SIGN_BIT = DW'(1) << (DW - 1);

    mhpq_pkg::state_t  state_reg, state_next;
    mhpq_pkg::status_t status_reg, status_next;
    logic [PW-1:0]     count_reg, count_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     child_reg, child_next;
    logic [PW-1:0]     best_pos_reg, best_pos_next;
    logic [DW-1:0]     key_reg, key_next;
    logic [DW-1:0]     best_reg, best_next;
    logic [DW-1:0]     top_reg, top_next;

    logic              accept;
    logic              full;
    logic [DW-1:0]     in_key;
    logic [DW-1:0]     cmp_a, cmp_b;
    logic              cmp_lt;
    logic [PW-1:0]     half_pos;
    logic [PW-1:0]     count_dec;
    logic [CW-1:0]     next_child;
    logic              next_child_ok;
    logic              right_exists;
    logic signed [DW-1:0] top_val;

    assign req.ready = (state_reg == mhpq_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == PW'(CAPACITY));
    // Keys carry the sign bit inverted so that an unsigned compare orders them.
    assign in_key    = DW'($unsigned(req.value)) ^ SIGN_BIT;

    assign half_pos      = pos_reg >> 1;
    assign count_dec     = count_reg - PW'(1);
    assign next_child    = {best_pos_reg, 1'b0};
    assign next_child_ok = (next_child <= {1'b0, count_reg});
    assign right_exists  = (child_reg < count_reg);

    // Shared comparator: every ordering decision goes through this one unit.
    always_comb
    begin
        unique case (state_reg)
            mhpq_pkg::S_RM_RIGHT:
            begin
                cmp_a = best_reg;
                cmp_b = mem_rd_data;
            end
            mhpq_pkg::S_RM_CMP:
            begin
                cmp_a = key_reg;
                cmp_b = best_reg;
            end
            default:
            begin
                cmp_a = mem_rd_data;
                cmp_b = key_reg;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == mhpq_pkg::MODE_INSERT)
                    begin
                        state_next = full ? mhpq_pkg::S_RESP : mhpq_pkg::S_INS_START;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? mhpq_pkg::S_RESP
                                                       : mhpq_pkg::S_RM_TOP;
                    end
                end
            end
            mhpq_pkg::S_INS_START:
            begin
                state_next = (pos_reg == PW'(1)) ? mhpq_pkg::S_RESP : mhpq_pkg::S_INS_CMP;
            end
            mhpq_pkg::S_INS_CMP:
            begin
                if (!cmp_lt)
                begin
                    state_next = mhpq_pkg::S_RESP;
                end
                else if (half_pos == PW'(1))
                begin
                    state_next = mhpq_pkg::S_INS_START;
                end
            end
            mhpq_pkg::S_RM_TOP:
            begin
                state_next = mhpq_pkg::S_RM_LAST;
            end
            mhpq_pkg::S_RM_LAST:
            begin
                state_next = (count_dec <= PW'(1)) ? mhpq_pkg::S_RESP : mhpq_pkg::S_RM_LEFT;
            end
            mhpq_pkg::S_RM_LEFT:
            begin
                state_next = right_exists ? mhpq_pkg::S_RM_RIGHT : mhpq_pkg::S_RM_CMP;
            end
            mhpq_pkg::S_RM_RIGHT:
            begin
                state_next = mhpq_pkg::S_RM_CMP;
            end
            mhpq_pkg::S_RM_CMP:
            begin
                if (!cmp_lt)
                begin
                    state_next = mhpq_pkg::S_RESP;
                end
                else
                begin
                    state_next = next_child_ok ? mhpq_pkg::S_RM_LEFT : mhpq_pkg::S_RM_PUT;
                end
            end
            mhpq_pkg::S_RM_PUT:
            begin
                state_next = mhpq_pkg::S_RESP;
            end
            mhpq_pkg::S_RESP:
            begin
                if (resp_ready)
                begin
                    state_next = mhpq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and store control
    always_comb
    begin
        status_next   = status_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        child_next    = child_reg;
        best_pos_next = best_pos_reg;
        key_next      = key_reg;
        best_next     = best_reg;
        top_next      = top_reg;
        mem_ctl       = '0;
        mem_rd_addr   = '0;
        mem_wr_addr   = AW'(pos_reg - PW'(1));
        mem_wr_data   = key_reg;

        unique case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req.mode == mhpq_pkg::MODE_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = mhpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next = mhpq_pkg::ST_INSERTED;
                            count_next  = count_reg + PW'(1);
                            pos_next    = count_reg + PW'(1);
                            key_next    = in_key;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = mhpq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        status_next   = mhpq_pkg::ST_REMOVED;
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = '0;
                    end
                end
            end
            mhpq_pkg::S_INS_START:
            begin
                if (pos_reg == PW'(1))
                begin
                    mem_ctl.wr_en = 1'b1;
                end
                else
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_rd_addr   = AW'(half_pos - PW'(1));
                end
            end
            mhpq_pkg::S_INS_CMP:
            begin
                mem_ctl.wr_en = 1'b1;
                if (cmp_lt)
                begin
                    // Parent is smaller: move it down and climb one level.
                    mem_wr_data = mem_rd_data;
                    pos_next    = half_pos;
                    if (half_pos != PW'(1))
                    begin
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = AW'((half_pos >> 1) - PW'(1));
                    end
                end
            end
            mhpq_pkg::S_RM_TOP:
            begin
                top_next      = mem_rd_data;
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = AW'(count_reg - PW'(1));
            end
            mhpq_pkg::S_RM_LAST:
            begin
                key_next   = mem_rd_data;
                count_next = count_dec;
                pos_next   = PW'(1);
                child_next = PW'(2);
                if (count_dec == PW'(1))
                begin
                    mem_ctl.wr_en = 1'b1;
                    mem_wr_addr   = '0;
                    mem_wr_data   = mem_rd_data;
                end
                else if (count_dec != '0)
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_rd_addr   = AW'(1);
                end
            end
            mhpq_pkg::S_RM_LEFT:
            begin
                best_next     = mem_rd_data;
                best_pos_next = child_reg;
                if (right_exists)
                begin
                    mem_ctl.rd_en = 1'b1;
                    mem_rd_addr   = AW'(child_reg);
                end
            end
            mhpq_pkg::S_RM_RIGHT:
            begin
                // Right child wins only when strictly larger.
                if (cmp_lt)
                begin
                    best_next     = mem_rd_data;
                    best_pos_next = child_reg + PW'(1);
                end
            end
            mhpq_pkg::S_RM_CMP:
            begin
                mem_ctl.wr_en = 1'b1;
                if (cmp_lt)
                begin
                    mem_wr_data = best_reg;
                    pos_next    = best_pos_reg;
                    if (next_child_ok)
                    begin
                        child_next    = PW'(next_child);
                        mem_ctl.rd_en = 1'b1;
                        mem_rd_addr   = AW'(next_child - CW'(1));
                    end
                end
            end
            mhpq_pkg::S_RM_PUT:
            begin
                mem_ctl.wr_en = 1'b1;
            end
            mhpq_pkg::S_RESP:
            begin
                mem_ctl = '0;
            end
            default:
            begin
                mem_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        child_reg    <= child_next;
        best_pos_reg <= best_pos_next;
        key_reg      <= key_next;
        best_reg     <= best_next;
        top_reg      <= top_next;
    end

    assign top_val            = $signed(top_reg ^ SIGN_BIT);
    assign resp.valid         = (state_reg == mhpq_pkg::S_RESP);
    assign resp.status        = status_reg;
    assign resp.removed_value = (status_reg == mhpq_pkg::ST_REMOVED) ? VW'(top_val) : '0;
    assign resp.entry_count   = CNTW'(count_reg);

endmodule

// ----- rtl/core/mhpq_checker.sv -----
// Port-level checks for the max-heap priority queue, bound to the top level.
// Depends on mhpq_pkg and max_heap_priority_queue.
module mhpq_checker #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [mhpq_pkg::STATUS_W-1:0] status,
    input logic [mhpq_pkg::VALUE_W-1:0]  removed_value,
    input logic [mhpq_pkg::COUNT_W-1:0]  entry_count
);

    localparam int CNTW = mhpq_pkg::COUNT_W;

    // Hold a stalled result.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(removed_value) && $stable(entry_count))
        else $error("rsp changed while stalled");

    // One request in flight: ready drops right after a transaction.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req accepted while another is in flight");

    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != mhpq_pkg::ST_REMOVED |-> removed_value == '0)
        else $error("removed_value nonzero without a removal");

    a_full_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (status != mhpq_pkg::ST_FULL || entry_count == CNTW'(CAPACITY))
            && (status != mhpq_pkg::ST_EMPTY || entry_count == '0))
        else $error("full or empty status disagrees with entry_count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == mhpq_pkg::ST_INSERTED |-> entry_count != '0)
        else $error("insert reported with zero entries");

endmodule

bind max_heap_priority_queue mhpq_checker #(
    .CAPACITY (CAPACITY)
) u_mhpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .removed_value (rsp.removed_value),
    .entry_count   (rsp.entry_count)
);

// ----- sim/max_heap_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// Testbench for max_heap_priority_queue: sends insert/remove transactions in bursts,
// predicts every response with a behavioral heap and compares them field by field.
// Depends on mhpq_pkg, mhpq_req_if / mhpq_rsp_if and the RTL top level.
module max_heap_priority_queue_tb;

    localparam int HEAP_DEPTH     = mhpq_pkg::CAPACITY_DEF;
    localparam int VW             = mhpq_pkg::VALUE_W;
    localparam int CNTW           = mhpq_pkg::COUNT_W;
    localparam int HOLDOFF_CYCLES = 240;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 1750;

    typedef struct {
        mhpq_pkg::status_t    status;
        logic signed [VW-1:0] removed_value;
        logic [CNTW-1:0]      entry_count;
    } heap_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mhpq_req_if req_ch ();
    mhpq_rsp_if rsp_ch ();

    max_heap_priority_queue #(
        .CAPACITY   (HEAP_DEPTH),
        .DATA_WIDTH (VW)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Behavioral heap, positions 1..HEAP_DEPTH
    logic signed [VW-1:0] model_heap [1:HEAP_DEPTH];
    int                   model_count;

    heap_result_t expected_results [$];

    int  items_sent      = 0;
    int  inserts_done    = 0;
    int  removes_done    = 0;
    int  full_hits       = 0;
    int  empty_hits      = 0;
    int  results_checked = 0;
    int  mismatch_count  = 0;
    int  stall_cycles    = 0;
    logic holdoff_request = 1'b0;

    function automatic heap_result_t predict_heap_op(input logic op_mode,
                                                     input logic signed [VW-1:0] op_value);
        heap_result_t         res;
        int                   pos;
        int                   parent;
        int                   child;
        logic signed [VW-1:0] moved;
        res.removed_value = '0;
        if (op_mode == mhpq_pkg::MODE_INSERT)
        begin
            if (model_count >= HEAP_DEPTH)
            begin
                res.status = mhpq_pkg::ST_FULL;
                full_hits++;
            end
            else
            begin
                model_count++;
                pos = model_count;
                // climb only past strictly smaller parents
                while (pos != 1 && op_value > model_heap[pos / 2])
                begin
                    model_heap[pos] = model_heap[pos / 2];
                    pos = pos / 2;
                end
                model_heap[pos] = op_value;
                res.status = mhpq_pkg::ST_INSERTED;
                inserts_done++;
            end
        end
        else if (model_count == 0)
        begin
            res.status = mhpq_pkg::ST_EMPTY;
            empty_hits++;
        end
        else
        begin
            res.removed_value = model_heap[1];
            moved = model_heap[model_count];
            model_count--;
            parent = 1;
            child  = 2;
            while (child <= model_count)
            begin
                // right child wins only when strictly larger
                if (child < model_count && model_heap[child] < model_heap[child + 1])
                    child++;
                if (moved >= model_heap[child])
                    break;
                model_heap[parent] = model_heap[child];
                parent = child;
                child  = child * 2;
            end
            if (model_count > 0)
                model_heap[parent] = moved;
            res.status = mhpq_pkg::ST_REMOVED;
            removes_done++;
        end
        res.entry_count = model_count[CNTW-1:0];
        return res;
    endfunction

    function automatic logic signed [VW-1:0] pick_value();
        logic signed [VW-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = $signed($urandom_range(0, 8)) - 4;
            7:          v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            8:          v = 32'sh7FFF_FFFF - $signed($urandom_range(0, 3));
            default:    v = 32'sh8000_0000 + $signed($urandom_range(0, 3));
        endcase
        return v;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance with valid held.
    task automatic send_op(input logic op_mode, input logic signed [VW-1:0] op_value);
        heap_result_t want;
        req_ch.valid = 1'b1;
        req_ch.mode  = op_mode;
        req_ch.value = op_value;
        forever
        begin
            @(posedge clk);
            if (req_ch.ready)
                break;
        end
        want = predict_heap_op(op_mode, op_value);
        expected_results.push_back(want);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic pause_sender(input int cycles);
        req_ch.valid = 1'b0;
        req_ch.mode  = 1'($urandom_range(0, 1));
        req_ch.value = $urandom;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic maybe_pause();
        if ($urandom_range(0, 2) == 0)
            pause_sender($urandom_range(1, 6));
    endtask

    task automatic test_directed_extremes();
        send_op(mhpq_pkg::MODE_REMOVE, 32'sh1234_5678);   // remove from an empty heap
        send_op(mhpq_pkg::MODE_INSERT, 32'sh7FFF_FFFF);
        send_op(mhpq_pkg::MODE_INSERT, 32'sh8000_0000);
        pause_sender(3);
        send_op(mhpq_pkg::MODE_INSERT, 32'sh0000_0000);
        send_op(mhpq_pkg::MODE_INSERT, -32'sd1);
        send_op(mhpq_pkg::MODE_INSERT, 32'sd1);
        send_op(mhpq_pkg::MODE_INSERT, 32'sd5);
        pause_sender(1);
        send_op(mhpq_pkg::MODE_INSERT, 32'sd5);           // equal to its parent
        send_op(mhpq_pkg::MODE_INSERT, -32'sd1);
        send_op(mhpq_pkg::MODE_INSERT, 32'sh8000_0000);
        repeat (10)
        begin
            send_op(mhpq_pkg::MODE_REMOVE, $urandom);
            maybe_pause();
        end
        send_op(mhpq_pkg::MODE_REMOVE, 32'shFFFF_FFFF);   // empty again
        send_op(mhpq_pkg::MODE_INSERT, 32'sh8000_0000);
        send_op(mhpq_pkg::MODE_REMOVE, 32'sh0000_0000);
        pause_sender(2);
    endtask

    task automatic test_full_and_drain();
        while (model_count < HEAP_DEPTH)
        begin
            send_op(mhpq_pkg::MODE_INSERT, pick_value());
            maybe_pause();
        end
        send_op(mhpq_pkg::MODE_INSERT, 32'sh7FFF_FFFF);   // full: nothing changes
        send_op(mhpq_pkg::MODE_INSERT, pick_value());
        while (model_count > 0)
        begin
            send_op(mhpq_pkg::MODE_REMOVE, $urandom);
            maybe_pause();
        end
        send_op(mhpq_pkg::MODE_REMOVE, $urandom);
        pause_sender(2);
    endtask

    // Receiver holds off while inserts keep coming, so the request side stalls.
    task automatic test_backpressure();
        holdoff_request = 1'b1;
        repeat (16) send_op(mhpq_pkg::MODE_INSERT, pick_value());
        repeat (16) send_op(mhpq_pkg::MODE_REMOVE, $urandom);
        pause_sender(4);
    endtask

    task automatic test_random_traffic(input int count);
        int sent;
        int burst;
        int insert_pct;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 20;
            endcase
            burst = $urandom_range(1, 40);
            repeat (burst)
            begin
                if ($urandom_range(1, 100) <= insert_pct)
                    send_op(mhpq_pkg::MODE_INSERT, pick_value());
                else
                    send_op(mhpq_pkg::MODE_REMOVE, $urandom);
                sent++;
            end
            // keep some bursts back to back
            if ($urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 15));
        end
        pause_sender(1);
    endtask

    // Receiver: ready follows one of four patterns, redrawn when its phase runs out; hold off when asked.
    initial
    begin : receiver
        int pattern;
        int phase;
        pattern = 0;
        phase   = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_request)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
                holdoff_request = 1'b0;
            end
            if (phase == 0)
            begin
                pattern = $urandom_range(0, 3);
                phase   = $urandom_range(16, 96);
            end
            phase--;
            case (pattern)
                0:       rsp_ch.ready = 1'b1;
                1:       rsp_ch.ready = 1'($urandom_range(0, 1));
                2:       rsp_ch.ready = ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready = (phase % 4 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : check_response
        heap_result_t got;
        heap_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status        = mhpq_pkg::status_t'(rsp_ch.status);
            got.removed_value = rsp_ch.removed_value;
            got.entry_count   = rsp_ch.entry_count;
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: response with nothing pending: %s %0d value %0d count %0d",
                             $realtime, "status", got.status, got.removed_value,
                             got.entry_count);
            end
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (got.status !== want.status || got.removed_value !== want.removed_value
                    || got.entry_count !== want.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: result %0d: expected status %0d value %0d count %0d,",
                                 $realtime, results_checked, want.status,
                                 want.removed_value, want.entry_count);
                        $display("    got status %0d value %0d count %0d",
                                 got.status, got.removed_value, got.entry_count);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles, %0d results pending",
                         WATCHDOG_LIMIT, expected_results.size());
                $display("max_heap_priority_queue: mismatch");
                $finish;
            end
        end
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.mode  = mhpq_pkg::MODE_INSERT;
        req_ch.value = '0;
        model_count  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_extremes();
        test_full_and_drain();
        test_backpressure();
        test_random_traffic(RANDOM_ITEMS);

        forever
        begin
            @(posedge clk);
            if (expected_results.size() == 0)
                break;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests: %0d inserts, %0d removes, %0d on a full heap,",
                 items_sent, inserts_done, removes_done, full_hits);
        $display("%0d on an empty one; checked %0d responses, %0d mismatches",
                 empty_hits, results_checked, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("max_heap_priority_queue: match");
        else
            $display("max_heap_priority_queue: mismatch");
        $finish;
    end

endmodule
